// ===== design/imv_pkg.sv =====
// ---------------------------------------------------------------------------
// imv_pkg: shared constants and types
// Fixed-point formats, kind codes, Taylor divisors and the structs that
// travel between the pipeline sections.
// ---------------------------------------------------------------------------
package imv_pkg;

  localparam int FRAC_W   = 16;
  localparam int ENERGY_W = 24;
  localparam int KIND_W   = 2;
  localparam int UNI_W    = FRAC_W;
  localparam int TOTAL_W  = ENERGY_W + 1;
  localparam int MOM_W    = ENERGY_W + 2;
  localparam int ROOT_W   = ENERGY_W + 1;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SIN_W    = FRAC_W + 1;
  localparam int DIR_W    = 31;
  localparam int Q32_W    = 33;

  localparam logic [KIND_W-1:0] KIND_PHOTON   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ELECTRON = 2'd1;

  localparam longint unsigned MASS_VAL = ((64'd511 << FRAC_W) + 64'd500) / 64'd1000;
  localparam logic [FRAC_W-1:0] MASS_FX = MASS_VAL[FRAC_W-1:0];

  localparam logic [34:0]      TWO_PI_Q32 = 35'd26986075409;
  localparam logic [Q32_W-1:0] Q32_ONE    = 33'h1_0000_0000;

  localparam int HORNER_STEPS = 6;
  localparam int SIN_STEPS    = 5;

  localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  // last sine entry is never used: the sine series has one step less
  localparam logic [7:0] SIN_DIV [HORNER_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd6};

  localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
    32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)};
  localparam logic [31:0] SIN_RCP [HORNER_STEPS] = '{
    32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
    32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd6)};

  localparam int SQ_LAT    = ROOT_W;
  localparam int SC_LAT    = 1 + 3 * HORNER_STEPS + 2;
  localparam int SC_PAD    = SQ_LAT - SC_LAT;
  localparam int SCALE_LAT = 3;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } imv_ang_t;

  typedef struct packed {
    logic [Q32_W-1:0] cm;
    logic             cn;
    logic [Q32_W-1:0] sm;
    logic             sn;
  } imv_dir_t;

  typedef struct packed {
    logic               kind;
    logic [TOTAL_W-1:0] etot;
    logic               zneg;
    logic [FRAC_W:0]    cz;
  } imv_side_t;

endpackage

// ===== design/imv_ifs.sv =====
// ---------------------------------------------------------------------------
// imv channel interfaces
// Request channel (particle record) and result channel (energy, momentum).
// ---------------------------------------------------------------------------
interface imv_req_if;
  logic                          valid;
  logic                          ready;
  logic [imv_pkg::KIND_W-1:0]    particle_kind;
  logic [imv_pkg::ENERGY_W-1:0]  kinetic_energy;
  logic [imv_pkg::UNI_W-1:0]     uniform_polar;
  logic [imv_pkg::UNI_W-1:0]     uniform_azimuth;

  modport source (output valid, output particle_kind, output kinetic_energy,
                  output uniform_polar, output uniform_azimuth, input ready);
  modport sink   (input valid, input particle_kind, input kinetic_energy,
                  input uniform_polar, input uniform_azimuth, output ready);
endinterface

interface imv_res_if;
  logic                               valid;
  logic                               ready;
  logic                               kind_out;
  logic [imv_pkg::TOTAL_W-1:0]        total_energy;
  logic signed [imv_pkg::MOM_W-1:0]   momentum_x;
  logic signed [imv_pkg::MOM_W-1:0]   momentum_y;
  logic signed [imv_pkg::MOM_W-1:0]   momentum_z;

  modport source (output valid, output kind_out, output total_energy,
                  output momentum_x, output momentum_y, output momentum_z, input ready);
  modport sink   (input valid, input kind_out, input total_energy,
                  input momentum_x, input momentum_y, input momentum_z, output ready);
endinterface

// ===== design/imv_sqrt.sv =====
// ---------------------------------------------------------------------------
// imv_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// ---------------------------------------------------------------------------
module imv_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [imv_pkg::RAD_W-1:0]   rad_i,
  output logic [imv_pkg::ROOT_W-1:0]  root_o
);

  localparam int RW = imv_pkg::ROOT_W;
  localparam int AW = imv_pkg::RAD_W;
  localparam int MW = RW + 2;

  logic [MW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [AW-1:0] rad_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_bit
    logic [MW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [AW-1:0] rad_in;
    logic [MW-1:0] cur;
    logic [MW-1:0] trial;
    logic [MW-1:0] rem_nxt;
    logic [RW-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    assign cur   = {rem_in[MW-3:0], rad_in[AW-1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_comb begin
      if (cur >= trial) begin
        rem_nxt  = cur - trial;
        root_nxt = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {root_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= {rad_in[AW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_r[RW-1];

endmodule

// ===== design/imv_sincos.sv =====
// ---------------------------------------------------------------------------
// imv_sincos: pipelined sine and cosine of the azimuth
// Horner Taylor series in Q32, three stages per term, then octant fold-back.
// ---------------------------------------------------------------------------
module imv_sincos (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         x_i,
  input  logic [1:0]          quad_i,
  input  logic                swap_i,
  output imv_pkg::imv_dir_t   dir_o
);

  localparam int N  = imv_pkg::HORNER_STEPS;
  localparam int QW = imv_pkg::Q32_W;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  // 1 - floor(m / d), with q0 an estimate at most one below the quotient
  function automatic logic [QW-1:0] horner_next(input logic [31:0] m,
                                                input logic [31:0] q0,
                                                input logic [7:0]  d);
    logic [39:0]   qd;
    logic [31:0]   rem;
    logic [QW-1:0] q;
    qd  = q0 * d;
    rem = m - qd[31:0];
    q   = {1'b0, q0} + ((rem >= {24'b0, d}) ? 33'd1 : 33'd0);
    return imv_pkg::Q32_ONE - q;
  endfunction

  imv_pkg::imv_ang_t g_r  [N+1];
  logic [QW-1:0]     tc_r [N+1];
  logic [QW-1:0]     ts_r [N+1];
  imv_pkg::imv_ang_t ga_r [N];
  imv_pkg::imv_ang_t gb_r [N];
  logic [31:0]       mca_r [N];
  logic [31:0]       msa_r [N];
  logic [31:0]       mcb_r [N];
  logic [31:0]       msb_r [N];
  logic [31:0]       qcb_r [N];
  logic [31:0]       qsb_r [N];
  logic [QW-1:0]     tsa_r [N];
  logic [QW-1:0]     tsb_r [N];

  logic [63:0] x2_full;
  assign x2_full = x_i * x_i;

  always_ff @(posedge clk) begin
    if (en) begin
      g_r[0].x    <= x_i;
      g_r[0].x2   <= x2_full[63:32];
      g_r[0].quad <= quad_i;
      g_r[0].swap <= swap_i;
      tc_r[0]     <= imv_pkg::Q32_ONE;
      ts_r[0]     <= imv_pkg::Q32_ONE;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_term
    logic [64:0]   mc_full;
    logic [64:0]   ms_full;
    logic [63:0]   qc_full;
    logic [63:0]   qs_full;
    logic [QW-1:0] tc_nxt;
    logic [QW-1:0] ts_nxt;

    assign mc_full = g_r[k].x2 * tc_r[k];
    assign ms_full = g_r[k].x2 * ts_r[k];
    assign qc_full = mca_r[k] * imv_pkg::COS_RCP[k];
    assign qs_full = msa_r[k] * imv_pkg::SIN_RCP[k];
    assign tc_nxt  = horner_next(mcb_r[k], qcb_r[k], imv_pkg::COS_DIV[k]);
    assign ts_nxt  = (k < imv_pkg::SIN_STEPS) ?
                     horner_next(msb_r[k], qsb_r[k], imv_pkg::SIN_DIV[k]) : tsb_r[k];

    always_ff @(posedge clk) begin
      if (en) begin
        ga_r[k]   <= g_r[k];
        mca_r[k]  <= mc_full[63:32];
        msa_r[k]  <= ms_full[63:32];
        tsa_r[k]  <= ts_r[k];
        gb_r[k]   <= ga_r[k];
        mcb_r[k]  <= mca_r[k];
        msb_r[k]  <= msa_r[k];
        qcb_r[k]  <= qc_full[63:32];
        qsb_r[k]  <= qs_full[63:32];
        tsb_r[k]  <= tsa_r[k];
        g_r[k+1]  <= gb_r[k];
        tc_r[k+1] <= tc_nxt;
        ts_r[k+1] <= ts_nxt;
      end
    end
  end

  // sine needs one last multiply by x
  logic [64:0]   sv_full;
  logic [31:0]   sv_r;
  logic [QW-1:0] cv_r;
  logic [1:0]    quad_r;
  logic          swap_r;
  imv_pkg::imv_dir_t dir_r;
  imv_pkg::imv_dir_t dir_nxt;
  logic [QW-1:0] ca;
  logic [QW-1:0] sa;

  assign sv_full = g_r[N].x * ts_r[N];

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r   <= sv_full[63:32];
      cv_r   <= tc_r[N];
      quad_r <= g_r[N].quad;
      swap_r <= g_r[N].swap;
    end
  end

  // fold the octant back and place by quadrant
  always_comb begin
    ca = swap_r ? {1'b0, sv_r} : cv_r;
    sa = swap_r ? cv_r : {1'b0, sv_r};
    case (quad_r)
      QUAD_I: begin
        dir_nxt = '{cm: ca, cn: 1'b0, sm: sa, sn: 1'b0};
      end
      QUAD_II: begin
        dir_nxt = '{cm: sa, cn: 1'b1, sm: ca, sn: 1'b0};
      end
      QUAD_III: begin
        dir_nxt = '{cm: ca, cn: 1'b1, sm: sa, sn: 1'b1};
      end
      default: begin
        dir_nxt = '{cm: sa, cn: 1'b0, sm: ca, sn: 1'b1};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_r <= dir_nxt;
    end
  end

  assign dir_o = dir_r;

endmodule

// ===== design/imv_scale.sv =====
// ---------------------------------------------------------------------------
// imv_scale: direction cosines and momentum components
// Rounds the direction to Q30, scales by |p| and applies signs, three stages.
// ---------------------------------------------------------------------------
module imv_scale (
  input  logic                               clk,
  input  logic                               en,
  input  imv_pkg::imv_side_t                 side_i,
  input  imv_pkg::imv_dir_t                  dir_i,
  input  logic [imv_pkg::ROOT_W-1:0]         p_i,
  input  logic [imv_pkg::SIN_W-1:0]          s_i,
  output logic                               kind_o,
  output logic [imv_pkg::TOTAL_W-1:0]        energy_o,
  output logic signed [imv_pkg::MOM_W-1:0]   mx_o,
  output logic signed [imv_pkg::MOM_W-1:0]   my_o,
  output logic signed [imv_pkg::MOM_W-1:0]   mz_o
);

  localparam int F   = imv_pkg::FRAC_W;
  localparam int DW  = imv_pkg::DIR_W;
  localparam int PW  = imv_pkg::ROOT_W;
  localparam int MW  = imv_pkg::MOM_W;
  localparam int XW  = imv_pkg::SIN_W + imv_pkg::Q32_W + 1;
  localparam int HW  = PW + DW - 15;
  localparam int LW  = PW + 15;
  localparam logic [XW-1:0] XRND = XW'(1) << (F + 1);

  function automatic logic [MW-1:0] round_q30(input logic [HW-1:0] hi,
                                              input logic [LW-1:0] lo,
                                              input logic          neg);
    logic [HW:0]   sum;
    logic [MW-1:0] mag;
    sum = {1'b0, hi} + (HW+1)'(lo >> 15) + (HW+1)'(15'h4000);
    mag = sum[15 +: MW];
    return neg ? (~mag + 1'b1) : mag;
  endfunction

  // stage A: direction in Q30
  logic [XW-1:0] dx_full;
  logic [XW-1:0] dy_full;
  logic [DW-1:0] dxa_r, dya_r, dza_r;
  logic [PW-1:0] pa_r;
  imv_pkg::imv_side_t sa_r, sb_r;
  logic          cna_r, sna_r, cnb_r, snb_r;

  assign dx_full = s_i * dir_i.cm + XRND;
  assign dy_full = s_i * dir_i.sm + XRND;

  always_ff @(posedge clk) begin
    if (en) begin
      dxa_r <= dx_full[F+2 +: DW];
      dya_r <= dy_full[F+2 +: DW];
      dza_r <= DW'(side_i.cz) << (30 - F);
      pa_r  <= p_i;
      sa_r  <= side_i;
      cna_r <= dir_i.cn;
      sna_r <= dir_i.sn;
    end
  end

  // stage B: split products
  logic [HW-1:0] hx_r, hy_r, hz_r;
  logic [LW-1:0] lx_r, ly_r, lz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hx_r  <= pa_r * dxa_r[DW-1:15];
      hy_r  <= pa_r * dya_r[DW-1:15];
      hz_r  <= pa_r * dza_r[DW-1:15];
      lx_r  <= pa_r * dxa_r[14:0];
      ly_r  <= pa_r * dya_r[14:0];
      lz_r  <= pa_r * dza_r[14:0];
      sb_r  <= sa_r;
      cnb_r <= cna_r;
      snb_r <= sna_r;
    end
  end

  // stage C: round, sign and hold the result
  always_ff @(posedge clk) begin
    if (en) begin
      kind_o   <= sb_r.kind;
      energy_o <= sb_r.etot;
      mx_o     <= round_q30(hx_r, lx_r, cnb_r);
      my_o     <= round_q30(hy_r, ly_r, snb_r);
      mz_o     <= round_q30(hz_r, lz_r, sb_r.zneg);
    end
  end

endmodule

// ===== design/isotropic_momentum_vector_top.sv =====
// ---------------------------------------------------------------------------
// isotropic_momentum_vector_top: isotropic momentum for photon and electron
// Turns one particle record into total energy and a randomly oriented
// momentum vector.
// ---------------------------------------------------------------------------
// The block takes one request per clock unless the result side stalls. It
// has one front stage, 25 square-root stages and three scaling stages. The
// latency is set by the momentum square root, which resolves one root bit per
// stage; the Taylor sine/cosine section runs beside it and is padded to match.
// A request of a kind other than photon or electron is taken and produces no
// result. When the result side stalls the whole pipeline holds, and in_req
// ready follows out_res ready while a result is waiting.
module isotropic_momentum_vector_top (
  input  logic          clk,
  input  logic          rst_n,
  imv_req_if.sink       in_req,
  imv_res_if.source     out_res
);

  localparam int F   = imv_pkg::FRAC_W;
  localparam int EW  = imv_pkg::ENERGY_W;
  localparam int TW  = imv_pkg::TOTAL_W;
  localparam int SQL = imv_pkg::SQ_LAT;
  localparam int PAD = imv_pkg::SC_PAD;
  localparam int LAT = 1 + SQL + imv_pkg::SCALE_LAT;

  // advance the whole pipeline unless a finished result is stuck
  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv          = ~vld_r[LAT-1] | out_res.ready;
  assign in_req.ready = adv;

  // ---- front: decode the request ----
  logic                          is_e;
  logic                          kind_ok;
  logic [F-1:0]                  mass_sel;
  logic [TW-1:0]                 second;
  logic [EW+TW-1:0]              radp_full;
  logic [F:0]                    two_u1;
  logic [F:0]                    one_f;
  logic [F+1:0]                  comp_u1;
  logic [2*F+2:0]                rads_full;
  logic [31:0]                   p32;
  logic [29:0]                   ang_a;
  logic [30:0]                   ang_m;
  logic [29:0]                   ang_b;
  logic                          swap;
  logic [64:0]                   x_full;
  imv_pkg::imv_side_t            side_nxt;

  assign is_e     = in_req.particle_kind == imv_pkg::KIND_ELECTRON;
  assign kind_ok  = is_e || (in_req.particle_kind == imv_pkg::KIND_PHOTON);
  assign mass_sel = is_e ? imv_pkg::MASS_FX : '0;
  // photon: sqrt(E*E) = E, electron: sqrt(E*(E+2m))
  assign second    = {1'b0, in_req.kinetic_energy} + TW'({mass_sel, 1'b0});
  assign radp_full = in_req.kinetic_energy * second;

  assign two_u1    = {in_req.uniform_polar, 1'b0};
  assign one_f     = {1'b1, {F{1'b0}}};
  assign comp_u1   = {1'b1, {(F+1){1'b0}}} - {1'b0, two_u1};
  assign rads_full = comp_u1 * two_u1;

  assign side_nxt.kind = in_req.particle_kind[0];
  assign side_nxt.etot = {1'b0, in_req.kinetic_energy} + TW'(mass_sel);
  assign side_nxt.zneg = ~in_req.uniform_polar[F-1];
  assign side_nxt.cz   = side_nxt.zneg ? (one_f - two_u1) : (two_u1 - one_f);

  // fold the azimuth turn into the first eighth and convert to radians
  assign p32    = {in_req.uniform_azimuth, {(32-F){1'b0}}};
  assign ang_a  = p32[29:0];
  assign swap   = ang_a > 30'h2000_0000;
  assign ang_m  = 31'h4000_0000 - {1'b0, ang_a};
  assign ang_b  = swap ? ang_m[29:0] : ang_a;
  assign x_full = ang_b * imv_pkg::TWO_PI_Q32;

  logic [imv_pkg::RAD_W-1:0] radp_r;
  logic [imv_pkg::RAD_W-1:0] rads_r;
  logic [31:0]               x_r;
  logic [1:0]                quad_r;
  logic                      swap_r;
  imv_pkg::imv_side_t        side_r [SQL+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      radp_r    <= imv_pkg::RAD_W'(radp_full);
      rads_r    <= imv_pkg::RAD_W'(rads_full);
      x_r       <= x_full[63:32];
      quad_r    <= p32[31:30];
      swap_r    <= swap;
      side_r[0] <= side_nxt;
      for (int k = 1; k <= SQL; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // valid bits ride along; dropped kinds enter as bubbles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_req.valid & kind_ok};
    end
  end

  // ---- square roots: momentum magnitude and sin(theta) ----
  logic [imv_pkg::ROOT_W-1:0] p_root;
  logic [imv_pkg::ROOT_W-1:0] s_root;

  imv_sqrt u_sqrt_p (.clk(clk), .en(adv), .rad_i(radp_r), .root_o(p_root));
  imv_sqrt u_sqrt_s (.clk(clk), .en(adv), .rad_i(rads_r), .root_o(s_root));

  // ---- azimuth sine/cosine, padded to the root latency ----
  imv_pkg::imv_dir_t dir_sc;
  imv_pkg::imv_dir_t dir_r [PAD];

  imv_sincos u_sincos (
    .clk    (clk),
    .en     (adv),
    .x_i    (x_r),
    .quad_i (quad_r),
    .swap_i (swap_r),
    .dir_o  (dir_sc)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_r[0] <= dir_sc;
      for (int k = 1; k < PAD; k++) begin
        dir_r[k] <= dir_r[k-1];
      end
    end
  end

  // ---- scale and hold the result ----
  imv_scale u_scale (
    .clk      (clk),
    .en       (adv),
    .side_i   (side_r[SQL]),
    .dir_i    (dir_r[PAD-1]),
    .p_i      (p_root),
    .s_i      (s_root[imv_pkg::SIN_W-1:0]),
    .kind_o   (out_res.kind_out),
    .energy_o (out_res.total_energy),
    .mx_o     (out_res.momentum_x),
    .my_o     (out_res.momentum_y),
    .mz_o     (out_res.momentum_z)
  );

  assign out_res.valid = vld_r[LAT-1];

endmodule

// ===== design/imv_checker.sv =====
// ---------------------------------------------------------------------------
// imv_checker: port-level checks
// Watches the channels of the top level and is bound to it.
// ---------------------------------------------------------------------------
module imv_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [imv_pkg::TOTAL_W-1:0]       total_energy,
  input  logic signed [imv_pkg::MOM_W-1:0]  momentum_x,
  input  logic signed [imv_pkg::MOM_W-1:0]  momentum_y,
  input  logic signed [imv_pkg::MOM_W-1:0]  momentum_z
);

  localparam int MW = imv_pkg::MOM_W;

  logic [MW-1:0] ax, ay, az;
  logic          in_seen;

  assign ax      = momentum_x[MW-1] ? MW'(-momentum_x) : MW'(momentum_x);
  assign ay      = momentum_y[MW-1] ? MW'(-momentum_y) : MW'(momentum_y);
  assign az      = momentum_z[MW-1] ? MW'(-momentum_z) : MW'(momentum_z);
  assign in_seen = in_valid;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(total_energy) && $stable(momentum_x)
                                && $stable(momentum_y) && $stable(momentum_z))
    else $error("result changed while stalled");

  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    (in_seen || !in_seen) |-> (in_ready == (!out_valid || out_ready)))
    else $error("request ready does not follow result side");

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, ax} <= MW'(total_energy)) && ({1'b0, ay} <= MW'(total_energy))
                  && ({1'b0, az} <= MW'(total_energy)))
    else $error("momentum component exceeds total energy");

endmodule

bind isotropic_momentum_vector_top imv_checker u_imv_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .total_energy (out_res.total_energy),
  .momentum_x   (out_res.momentum_x),
  .momentum_y   (out_res.momentum_y),
  .momentum_z   (out_res.momentum_z)
);
